// ----- design/feedback_delay_line_unit_assert.svh -----
// Assertion macros for the feedback delay line unit
`ifndef FEEDBACK_DELAY_LINE_UNIT_ASSERT_SVH
`define FEEDBACK_DELAY_LINE_UNIT_ASSERT_SVH
// implication checked on every clock edge, off during reset
`define FDL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FDL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/fdl_pkg.sv -----
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types and constants of the feedback delay line unit.
// ----------------------------------------------------------------------------
package fdl_pkg;
  localparam int unsigned RegW = 16;
  // fraction bits of the delay position
  localparam int unsigned FracBits = 16;
  localparam logic [2:0] RegDelay    = 3'd0;
  localparam logic [2:0] RegFeedback = 3'd1;
  localparam logic [2:0] RegWet      = 3'd2;
  localparam logic [2:0] RegRate     = 3'd3;
  localparam logic [2:0] RegSmooth   = 3'd4;

  // controller commands to the datapath, one per step
  typedef enum logic [10:0] {
    CmdNone    = 11'b00000000001,
    CmdTarget  = 11'b00000000010,
    CmdDiv     = 11'b00000000100,
    CmdSmooth  = 11'b00000001000,
    CmdPos     = 11'b00000010000,
    CmdRead0   = 11'b00000100000,
    CmdRead1   = 11'b00001000000,
    CmdInterp  = 11'b00010000000,
    CmdFeed    = 11'b00100000000,
    CmdStore   = 11'b01000000000,
    CmdClear   = 11'b10000000000
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic load_x;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic clr_done;
  } sts_t;
endpackage

// ----- design/fdl_datapath.sv -----
// ----------------------------------------------------------------------------
// fdl_datapath
// Registers, ring store, delay-time calculation and arithmetic of the delay line.
// ----------------------------------------------------------------------------
module fdl_datapath #(
  parameter int unsigned BufferDepth = 131072,
  parameter int unsigned SampleWidth = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fdl_pkg::ctl_t                 ctl_i,
  output fdl_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [fdl_pkg::RegW-1:0]      cfg_data_i,
  input  logic signed [SampleWidth-1:0] in_sample_i,
  output logic signed [SampleWidth-1:0] out_sample_o
);
  localparam int unsigned FracBits = fdl_pkg::FracBits;
  localparam int unsigned AW = $clog2(BufferDepth);
  localparam int unsigned DW = AW + FracBits;           // delay width
  localparam int unsigned TW = 34;                      // target width
  localparam logic [DW-1:0] MaxDelay = DW'(BufferDepth - 1) << FracBits;
  localparam logic [DW:0] Span = (DW+1)'(BufferDepth) << FracBits;
  // target calculation phases, counted down
  localparam logic [2:0] PhQuot = 3'd4;
  localparam logic [2:0] PhRem  = 3'd3;
  localparam logic [2:0] PhProd = 3'd2;
  localparam logic [2:0] PhSum  = 3'd1;
  // ceil(2^22 / 5): exact quotient by five for operands below 2^20
  localparam logic [19:0] Recip5T = 20'd838861;
  localparam int unsigned FU = SampleWidth + 4;
  localparam int unsigned FK = SampleWidth + 6;
  localparam logic [FU-1:0] Recip5F = FU'(((64'd1 << FK) + 64'd4) / 64'd5);
  localparam logic [SampleWidth+5:0] FBias = (SampleWidth+6)'(20) << SampleWidth;
  localparam logic signed [SampleWidth+1:0] FOff = (SampleWidth+2)'(1) << SampleWidth;
  localparam logic signed [SampleWidth+1:0] SatHi = (SampleWidth+2)'((1 << (SampleWidth-1)) - 1);
  localparam logic signed [SampleWidth+1:0] SatLo = -SatHi - 1;

  logic [15:0] dk_q, fk_q, wet_q, sr_q, sc_q;
  logic [AW-1:0] wp_q, i0_q, clr_q;
  logic [DW-1:0] sm_q;
  logic [2:0]    cnt_q;
  logic [21:0]   kk_q;
  logic [17:0]   qk_q;
  logic [4:0]    rk_q;
  logic [20:0]   mr_q;
  logic [TW-1:0] hi_q, tgt_q;
  logic signed [SampleWidth+5:0] fw_q;
  logic signed [SampleWidth-1:0] x_q, y0_q, y1_q, rd_q, out_q;
  logic signed [SampleWidth:0]   y_q;
  logic [FracBits-1:0] t_q;
  logic signed [SampleWidth-1:0] mem [BufferDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dk_q <= '0; fk_q <= '0; wet_q <= '0; sr_q <= 16'd48000; sc_q <= 16'd655;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdl_pkg::RegDelay:    dk_q  <= cfg_data_i;
        fdl_pkg::RegFeedback: fk_q  <= cfg_data_i;
        fdl_pkg::RegWet:      wet_q <= cfg_data_i;
        fdl_pkg::RegRate:     sr_q  <= cfg_data_i;
        fdl_pkg::RegSmooth:   sc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // divide by twenty as a quarter then a reciprocal multiply by a fifth
  logic [19:0] rc_in;
  logic [39:0] rc_p;
  logic [17:0] rc_quo;
  assign rc_in = (cnt_q == PhQuot) ? kk_q[21:2] : {1'b0, mr_q[20:2]};
  assign rc_p = rc_in * Recip5T;
  assign rc_quo = rc_p[39:22];

  logic [DW-1:0] tgt_c;
  assign tgt_c = ({1'b0, tgt_q} > (TW+1)'(MaxDelay)) ? MaxDelay : DW'(tgt_q);

  logic signed [DW+1:0] diff;
  logic signed [DW+18:0] prod;
  logic signed [DW+2:0] sm_n;
  assign diff = $signed({2'b0, tgt_c}) - $signed({2'b0, sm_q});
  assign prod = diff * $signed({1'b0, sc_q});
  assign sm_n = $signed({3'b0, sm_q}) + (DW+3)'(prod >>> 16);

  logic [DW:0] wpf, pos;
  assign wpf = {1'b0, wp_q, FracBits'(0)};
  assign pos = (wpf < {1'b0, sm_q}) ? wpf + Span - {1'b0, sm_q} : wpf - {1'b0, sm_q};

  logic [AW-1:0] i1;
  assign i1 = (i0_q == AW'(BufferDepth - 1)) ? '0 : i0_q + 1'b1;

  logic signed [SampleWidth+FracBits+1:0] ip;
  assign ip = ($signed({y1_q[SampleWidth-1], y1_q}) - $signed({y0_q[SampleWidth-1], y0_q}))
              * $signed({1'b0, t_q});

  logic signed [SampleWidth+1:0] xy;
  logic signed [SampleWidth+24:0] fbp;
  assign xy = $signed({{2{x_q[SampleWidth-1]}}, x_q}) + $signed({y_q[SampleWidth], y_q});
  assign fbp = xy * $signed({1'b0, 5'd0, fk_q}) * $signed(6'sd19);

  // floor of the scaled feedback by twenty, biased positive for the multiply
  logic [SampleWidth+5:0] fv;
  logic [2*FU-1:0] fp;
  logic [SampleWidth+1:0] fquo;
  logic signed [SampleWidth+1:0] fq;
  logic signed [SampleWidth+1:0] st;
  assign fv = $unsigned(fw_q) + FBias;
  assign fp = fv[SampleWidth+5:2] * Recip5F;
  assign fquo = fp[2*FU-1:FK];
  assign fq = $signed(fquo) - FOff;
  assign st = (fq > SatHi) ? SatHi : (fq < SatLo) ? SatLo : fq;

  logic signed [SampleWidth+18:0] mix;
  logic signed [SampleWidth+2:0] mo;
  assign mix = x_q * $signed({1'b0, 17'h10000 - {1'b0, wet_q}})
             + y_q * $signed({2'b0, wet_q});
  assign mo = (SampleWidth+3)'(mix >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; sm_q <= '0; clr_q <= '0; cnt_q <= '0;
      kk_q <= '0; qk_q <= '0; rk_q <= '0; mr_q <= '0; hi_q <= '0; tgt_q <= '0;
      i0_q <= '0; t_q <= '0; x_q <= '0; y0_q <= '0; y1_q <= '0; y_q <= '0;
      fw_q <= '0; out_q <= '0;
    end else begin
      unique case (ctl_i.cmd)
        fdl_pkg::CmdTarget: begin
          kk_q <= 22'd65536 + 22'(dk_q) * 22'd39;
          cnt_q <= PhQuot;
        end
        fdl_pkg::CmdDiv: begin
          unique case (cnt_q)
            PhQuot: qk_q <= rc_quo;
            PhRem: begin
              rk_q <= 5'(kk_q - 22'(qk_q) * 22'd20);
              hi_q <= TW'(sr_q) * TW'(qk_q);
            end
            PhProd: mr_q <= 21'(sr_q) * 21'(rk_q);
            PhSum: tgt_q <= hi_q + TW'(rc_quo);
            default: ;
          endcase
          cnt_q <= cnt_q - 1'b1;
        end
        fdl_pkg::CmdSmooth: sm_q <= (sm_n > $signed({3'b0, MaxDelay})) ? MaxDelay : DW'(sm_n);
        fdl_pkg::CmdPos: begin
          i0_q <= (pos[DW:FracBits] >= (AW+1)'(BufferDepth)) ? AW'(BufferDepth-1)
                : AW'(pos[DW:FracBits]);
          t_q <= pos[FracBits-1:0];
        end
        fdl_pkg::CmdRead0: y0_q <= rd_q;
        fdl_pkg::CmdRead1: y1_q <= rd_q;
        fdl_pkg::CmdInterp: y_q <= $signed({y0_q[SampleWidth-1], y0_q})
                                   + (SampleWidth+1)'(ip >>> FracBits);
        fdl_pkg::CmdFeed: fw_q <= (SampleWidth+6)'(fbp >>> 16);
        fdl_pkg::CmdStore: begin
          out_q <= (mo > SatHi) ? SatHi[SampleWidth-1:0] : (mo < SatLo) ?
                   SatLo[SampleWidth-1:0] : mo[SampleWidth-1:0];
          wp_q <= (wp_q == AW'(BufferDepth - 1)) ? '0 : wp_q + 1'b1;
        end
        fdl_pkg::CmdClear: clr_q <= clr_q + 1'b1;
        default: ;
      endcase
      if (ctl_i.load_x) x_q <= in_sample_i;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == fdl_pkg::CmdClear) mem[clr_q] <= '0;
    else if (ctl_i.cmd == fdl_pkg::CmdStore) mem[wp_q] <= st[SampleWidth-1:0];
    rd_q <= mem[(ctl_i.cmd == fdl_pkg::CmdPos) ? AW'(pos[DW:FracBits]) : i1];
  end

  assign sts_o.div_done = (cnt_q == PhSum);
  assign sts_o.clr_done = (clr_q == AW'(BufferDepth - 1));
  assign out_sample_o = out_q;
endmodule

// ----- design/fdl_ctrl.sv -----
// ----------------------------------------------------------------------------
// fdl_ctrl
// Sequencer: clear pass after reset, then one sample at a time.
// ----------------------------------------------------------------------------
module fdl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  fdl_pkg::sts_t sts_i,
  output fdl_pkg::ctl_t ctl_o
);
  typedef enum logic [11:0] {
    StClear = 12'b000000000001, StIdle = 12'b000000000010, StTgt = 12'b000000000100,
    StDiv = 12'b000000001000, StSm = 12'b000000010000, StPos = 12'b000000100000,
    StRd0 = 12'b000001000000, StRd1 = 12'b000010000000, StIp = 12'b000100000000,
    StFb = 12'b001000000000, StSt = 12'b010000000000, StOut = 12'b100000000000
  } state_e;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StClear;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    ctl_o.cmd = fdl_pkg::CmdNone;
    ctl_o.load_x = 1'b0;
    unique case (state_q)
      StClear: begin ctl_o.cmd = fdl_pkg::CmdClear; if (sts_i.clr_done) state_d = StIdle; end
      StIdle: if (in_valid_i) begin ctl_o.load_x = 1'b1; state_d = StTgt; end
      StTgt: begin ctl_o.cmd = fdl_pkg::CmdTarget; state_d = StDiv; end
      StDiv: begin ctl_o.cmd = fdl_pkg::CmdDiv; if (sts_i.div_done) state_d = StSm; end
      StSm: begin ctl_o.cmd = fdl_pkg::CmdSmooth; state_d = StPos; end
      StPos: begin ctl_o.cmd = fdl_pkg::CmdPos; state_d = StRd0; end
      StRd0: begin ctl_o.cmd = fdl_pkg::CmdRead0; state_d = StRd1; end
      StRd1: begin ctl_o.cmd = fdl_pkg::CmdRead1; state_d = StIp; end
      StIp: begin ctl_o.cmd = fdl_pkg::CmdInterp; state_d = StFb; end
      StFb: begin ctl_o.cmd = fdl_pkg::CmdFeed; state_d = StSt; end
      StSt: begin ctl_o.cmd = fdl_pkg::CmdStore; state_d = StOut; end
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
endmodule

// ----- design/feedback_delay_line_unit.sv -----
// ----------------------------------------------------------------------------
// feedback_delay_line_unit
// Feedback delay with smoothed fractional delay and linear interpolation.
// ----------------------------------------------------------------------------
// channel | signals                          | direction
// input   | in_valid_i, in_stall_o, in_sample_i   | in
// output  | out_valid_o, out_stall_i, out_sample_o| out
// config  | cfg_we_i, cfg_idx_i, cfg_data_i       | in
// Each sample passes through twelve sequencing steps (four of them for the
// delay-time reciprocal divide), then the result is offered, and the idle
// state takes the next input only after the result is transferred.
// After reset a clear pass zeroes the store; no sample is taken
// meanwhile. A stalled result holds the unit until transferred.
module feedback_delay_line_unit #(
  parameter int unsigned BufferDepth = 131072,
  parameter int unsigned SampleWidth = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SampleWidth-1:0] in_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SampleWidth-1:0] out_sample_o
);
  fdl_pkg::ctl_t ctl;
  fdl_pkg::sts_t sts;

  fdl_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o,
                   .out_stall_i, .sts_i(sts), .ctl_o(ctl));

  fdl_datapath #(.BufferDepth(BufferDepth), .SampleWidth(SampleWidth)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_sample_i, .out_sample_o);
endmodule

// ----- design/fdl_checker.sv -----
// ----------------------------------------------------------------------------
// fdl_checker
// Port-level checks of the feedback delay line unit.
// ----------------------------------------------------------------------------
`include "feedback_delay_line_unit_assert.svh"
module fdl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);
  `FDL_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  `FDL_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `FDL_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
endmodule

bind feedback_delay_line_unit fdl_checker u_chk (.clk_i, .rst_ni, .in_valid_i,
  .in_stall_o, .out_valid_o, .out_stall_i);

// ----- tb/tb_feedback_delay_line_unit.sv -----
// ----------------------------------------------------------------------------
// tb_feedback_delay_line_unit
// Self-checking bench for the feedback delay line unit. A scoreboard keeps its
// own copy of the ring store, write pointer, smoothed delay and the knobs, and
// predicts each output sample from every input transfer. Settings change only
// while no sample is in flight. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_feedback_delay_line_unit;

  localparam int unsigned Depth     = 131072;
  localparam longint     FracOne    = 64'd65536;
  localparam longint     MaxDelayQ  = longint'(Depth - 1) * FracOne;
  localparam longint     SpanQ      = longint'(Depth) * FracOne;
  localparam int unsigned Settle    = 150;
  localparam longint     CycleLimit = 3000000;

  class echo_scoreboard;
    logic signed [15:0] ring[Depth];
    longint wr_ptr;
    longint smooth_q;
    longint knob_delay, knob_fb, knob_wet, rate, coeff;
    logic signed [15:0] expected_q[$];
    int errors;

    function new();
      for (int i = 0; i < Depth; i++) ring[i] = '0;
      wr_ptr = 0;
      smooth_q = 0;
      knob_delay = 0;
      knob_fb = 0;
      knob_wet = 0;
      rate = 48000;
      coeff = 655;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        fdl_pkg::RegDelay:    knob_delay = val;
        fdl_pkg::RegFeedback: knob_fb = val;
        fdl_pkg::RegWet:      knob_wet = val;
        fdl_pkg::RegRate:     rate = val;
        fdl_pkg::RegSmooth:   coeff = val;
        default: ;
      endcase
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // advance the echo by one sample and return the mixed output
    function logic signed [15:0] echo_step(logic signed [15:0] x_in);
      longint x, tgt, pos, i0, i1, frac, y0, y1, y, fed, mix;
      x = x_in;
      tgt = ((rate * (65536 + 39 * knob_delay)) << 16) / 1310720;
      if (tgt > MaxDelayQ) tgt = MaxDelayQ;
      smooth_q = smooth_q + floor_div(coeff * (tgt - smooth_q), 65536);
      if (smooth_q > MaxDelayQ) smooth_q = MaxDelayQ;
      pos = wr_ptr << 16;
      if (pos < smooth_q) pos = pos + SpanQ - smooth_q;
      else pos = pos - smooth_q;
      i0 = pos >> 16;
      if (i0 >= Depth) i0 = Depth - 1;
      frac = pos & (FracOne - 1);
      i1 = i0 + 1;
      if (i1 >= Depth) i1 -= Depth;
      y0 = ring[i0];
      y1 = ring[i1];
      y = y0 + floor_div((y1 - y0) * frac, FracOne);
      fed = floor_div((x + y) * 19 * knob_fb, 1310720);
      ring[wr_ptr] = 16'(clip16(fed));
      mix = floor_div(x * (65536 - knob_wet) + y * knob_wet, 65536);
      wr_ptr = (wr_ptr + 1) % Depth;
      return 16'(clip16(mix));
    endfunction

    function void note_input(logic signed [15:0] x);
      expected_q.push_back(echo_step(x));
    endfunction

    task report(string what, logic signed [15:0] got, logic signed [15:0] want);
      errors++;
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    endtask

    task check_result(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_q.size() == 0) begin
        report("unexpected out_sample", got, 0);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) report("out_sample", got, want);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] in_sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] out_sample_o;

  echo_scoreboard sb = new();
  longint cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  feedback_delay_line_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_sample_i,
    .out_valid_o, .out_stall_i, .out_sample_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_feedback_delay_line_unit: done, errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 90);
  endfunction

  task write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task configure(logic [15:0] dk, logic [15:0] fb, logic [15:0] wet,
                 logic [15:0] sr, logic [15:0] sc);
    write_reg(fdl_pkg::RegDelay, dk);
    write_reg(fdl_pkg::RegFeedback, fb);
    write_reg(fdl_pkg::RegWet, wet);
    write_reg(fdl_pkg::RegRate, sr);
    write_reg(fdl_pkg::RegSmooth, sc);
  endtask

  // offer one sample, hold it until transferred, then maybe drop valid
  task send_sample(logic signed [15:0] x);
    int gap;
    in_valid_i <= 1'b1;
    in_sample_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(x);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task drain();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  function logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 63)) - 16'd32;
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task send_random(int n);
    repeat (n) send_sample(rand_sample());
  endtask

  // receiver: random stall runs, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int run_left;
    bit run_val;
    hold_left = 0;
    run_left = 0;
    run_val = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_sample_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_val = !no_idle && ($urandom_range(0, 3) == 0);
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                  : $urandom_range(1, 4);
        end
        run_left--;
        out_stall_i <= run_val;
      end
    end
  end

  initial begin : stimulus
    logic signed [15:0] directed[$];
    directed = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555,
                 16'shaaaa, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh4000,
                 -16'sd16384, 16'sh7fff, 16'sh8000, 16'sh0001};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero delay (rate zero), full feedback, half wet: saturating feedback
    configure(16'd0, 16'hffff, 16'h8000, 16'd0, 16'hffff);
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // short delay, below 200 samples, so the echoes can come back within the run
    configure(16'($urandom()), 16'd50000, 16'd40000, 16'd100, 16'hffff);
    send_random(80);
    drain();

    // longest delay setting at the highest rate, no feedback, dry only
    configure(16'hffff, 16'd0, 16'd0, 16'hffff, 16'd0);
    send_random(20);
    drain();

    // slow smoothing towards a low-rate delay, fully wet
    configure(16'd0, 16'hffff, 16'hffff, 16'd8000, 16'd655);
    send_random(50);
    drain();

    // receiver holds off while samples keep coming, so the unit backs up
    configure(16'hffff, 16'd40000, 16'd30000, 16'd40, 16'd30000);
    hold_req = 1'b1;
    send_random(80);
    drain();

    // back-to-back transfers with no stalls, random knobs
    no_idle = 1'b1;
    configure(16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom_range(0, 80)), 16'($urandom()));
    send_random(60);
    drain();
    no_idle = 1'b0;

    configure(16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom_range(8000, 48000)), 16'($urandom()));
    send_random(60);
    drain();

    configure(16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom_range(10, 120)), 16'($urandom()));
    send_random(60);
    drain();

    if (sb.errors == 0) begin
      $display("tb_feedback_delay_line_unit: done, clean");
    end else begin
      $display("tb_feedback_delay_line_unit: done, errors");
    end
    $finish;
  end
endmodule
